[design/cmd_pkg.sv]
// shared types and constants for the complex multiply and divide block
package cmd_pkg;

	localparam int EPS_W = 16;
	localparam logic [EPS_W-1:0] EPS_RESET = 16'd17;

	typedef enum logic {
		REQ_MUL = 1'b0,
		REQ_DIV = 1'b1
	} req_t;

	typedef struct packed {
		logic valid;
		req_t op;
		logic neg_re;
		logic neg_im;
		logic sat_re;
		logic sat_im;
		logic zero;
	} ctl_t;

endpackage

[design/cmd_cell.sv]
// one quotient bit of both divider lanes, with its stage register
module cmd_cell #(
	parameter int DW   = 32,
	parameter int CW   = 90,
	parameter int DENW = 65,
	parameter int QB   = 33,
	parameter int BIT  = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cmd_pkg::ctl_t       in_ctl,
	input  logic [DENW-1:0]     in_den,
	input  logic [CW-1:0]       in_rem_re,
	input  logic [CW-1:0]       in_rem_im,
	input  logic [QB-1:0]       in_q_re,
	input  logic [QB-1:0]       in_q_im,
	input  logic [DW-1:0]       in_mres_re,
	input  logic [DW-1:0]       in_mres_im,
	output cmd_pkg::ctl_t       out_ctl,
	output logic [DENW-1:0]     out_den,
	output logic [CW-1:0]       out_rem_re,
	output logic [CW-1:0]       out_rem_im,
	output logic [QB-1:0]       out_q_re,
	output logic [QB-1:0]       out_q_im,
	output logic [DW-1:0]       out_mres_re,
	output logic [DW-1:0]       out_mres_im
);

	logic [CW-1:0] dsh;
	logic          ge_re, ge_im;
	logic [CW-1:0] nrem_re, nrem_im;
	logic [QB-1:0] qbit;

	always_comb begin
		dsh     = CW'(in_den) << BIT;
		ge_re   = in_rem_re >= dsh;
		ge_im   = in_rem_im >= dsh;
		nrem_re = ge_re ? in_rem_re - dsh : in_rem_re;
		nrem_im = ge_im ? in_rem_im - dsh : in_rem_im;
		qbit    = QB'(1) << BIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else if (en) begin
			out_ctl <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_den        <= in_den;
			out_rem_re     <= nrem_re;
			out_rem_im     <= nrem_im;
			out_q_re       <= ge_re ? (in_q_re | qbit) : in_q_re;
			out_q_im       <= ge_im ? (in_q_im | qbit) : in_q_im;
			out_mres_re    <= in_mres_re;
			out_mres_im    <= in_mres_im;
		end
	end

endmodule

[design/complex_multiply_divide.sv]
// top level: pipelined complex multiply and regularised complex divide
//
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       tdata a_real a_imag b_real b_imag, tuser req_type
// m_       out  m_tvalid / m_tready       tdata out_real out_imag, tuser saturated
// cfg_     in   cfg_valid / cfg_ready     cfg_data div_epsilon
//
// one item per cycle unless a stall at m_ holds the pipeline
// five arithmetic stages, then DATA_WIDTH+1 divider cells, one quotient bit each, then rounding
// a stall at m_ holds the whole pipeline; s_tready follows it
// reset clears the valid bits and sets div_epsilon to 17
module complex_multiply_divide #(
	parameter int FRAC_BITS  = 24,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// a_real, a_imag, b_real, b_imag
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
	// req_type
	input  logic                                    s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// out_real, out_imag
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
	// saturated
	output logic                                    m_tuser,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [cmd_pkg::EPS_W-1:0]               cfg_data
);

	localparam int DW      = DATA_WIDTH;
	localparam int TDW_OUT = ((2*DATA_WIDTH+7)/8)*8;
	localparam int PW      = 2*DW;
	localparam int SW      = 2*DW+2;
	localparam int AW      = SW-1;
	localparam int QB      = DW+1;
	localparam int DENW    = ((2*DW > cmd_pkg::EPS_W+FRAC_BITS) ? 2*DW
		: cmd_pkg::EPS_W+FRAC_BITS) + 1;
	localparam int NW      = AW+FRAC_BITS;
	localparam int CW      = (NW > DENW+QB) ? NW : DENW+QB;
	localparam logic [DW-1:0] LIM_P = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] LIM_N = {1'b1, {(DW-1){1'b0}}};

	logic en;
	logic [cmd_pkg::EPS_W-1:0] eps_q;

	// stage regs
	logic                v_s1, v_s2, v_s3, v_s4;
	cmd_pkg::req_t       op_s1, op_s2, op_s3, op_s4;
	logic [3:0]          sg_s1;
	logic [DW-1:0]       mg_s1 [4];
	logic [PW-1:0]       ac_s2, bd_s2, bc_s2, ad_s2, cc_s2, dd_s2;
	logic                sac_s2, sbd_s2, sbc_s2, sad_s2;
	logic signed [SW-1:0] num_re_s3, num_im_s3;
	logic [DENW-1:0]     den_s3, den_s4, den_s5;
	logic                neg_re_s4, neg_im_s4;
	logic [AW-1:0]       mag_re_s4, mag_im_s4;
	cmd_pkg::ctl_t       ctl_s5;
	logic [CW-1:0]       rem_re_s5, rem_im_s5;
	logic [DW-1:0]       mres_re_s5, mres_im_s5;

	// divider chain
	cmd_pkg::ctl_t   ch_ctl     [QB+1];
	logic [DENW-1:0] ch_den     [QB+1];
	logic [CW-1:0]   ch_rem_re  [QB+1];
	logic [CW-1:0]   ch_rem_im  [QB+1];
	logic [QB-1:0]   ch_q_re    [QB+1];
	logic [QB-1:0]   ch_q_im    [QB+1];
	logic [DW-1:0]   ch_mres_re [QB+1];
	logic [DW-1:0]   ch_mres_im [QB+1];

	logic                valid_q;
	logic [DW-1:0]       re_q, im_q;
	logic                sat_q;
	cmd_pkg::ctl_t       ctl_out_q;

	assign en        = !valid_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_q;
	assign m_tdata   = TDW_OUT'({im_q, re_q});
	assign m_tuser   = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= cmd_pkg::EPS_RESET;
		end else if (cfg_valid) begin
			eps_q <= cfg_data;
		end
	end

	// operand decode
	logic [DW-1:0] raw [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			raw[i] = s_tdata[i*DW +: DW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= ch_ctl[QB].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= cmd_pkg::req_t'(s_tuser);
			for (int i = 0; i < 4; i++) begin
				sg_s1[i] <= raw[i][DW-1];
				mg_s1[i] <= raw[i][DW-1] ? -raw[i] : raw[i];
			end
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			ac_s2  <= PW'(mg_s1[0]) * PW'(mg_s1[2]);
			bd_s2  <= PW'(mg_s1[1]) * PW'(mg_s1[3]);
			bc_s2  <= PW'(mg_s1[1]) * PW'(mg_s1[2]);
			ad_s2  <= PW'(mg_s1[0]) * PW'(mg_s1[3]);
			cc_s2  <= PW'(mg_s1[2]) * PW'(mg_s1[2]);
			dd_s2  <= PW'(mg_s1[3]) * PW'(mg_s1[3]);
			sac_s2 <= sg_s1[0] ^ sg_s1[2];
			sbd_s2 <= sg_s1[1] ^ sg_s1[3];
			sbc_s2 <= sg_s1[1] ^ sg_s1[2];
			sad_s2 <= sg_s1[0] ^ sg_s1[3];
		end
	end

	// sums and denominator
	logic signed [SW-1:0] t_ac, t_bd, t_bc, t_ad;
	always_comb begin
		t_ac = sac_s2 ? -$signed(SW'(ac_s2)) : $signed(SW'(ac_s2));
		t_bd = sbd_s2 ? -$signed(SW'(bd_s2)) : $signed(SW'(bd_s2));
		t_bc = sbc_s2 ? -$signed(SW'(bc_s2)) : $signed(SW'(bc_s2));
		t_ad = sad_s2 ? -$signed(SW'(ad_s2)) : $signed(SW'(ad_s2));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3 <= op_s2;
			if (op_s2 == cmd_pkg::REQ_MUL) begin
				num_re_s3 <= t_ac - t_bd;
				num_im_s3 <= t_bc + t_ad;
			end else begin
				num_re_s3 <= t_ac + t_bd;
				num_im_s3 <= t_bc - t_ad;
			end
			den_s3 <= DENW'(cc_s2) + DENW'(dd_s2) + (DENW'(eps_q) << FRAC_BITS);
		end
	end

	// sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			op_s4     <= op_s3;
			den_s4    <= den_s3;
			neg_re_s4 <= num_re_s3[SW-1];
			neg_im_s4 <= num_im_s3[SW-1];
			mag_re_s4 <= num_re_s3[SW-1] ? AW'(-num_re_s3) : AW'(num_re_s3);
			mag_im_s4 <= num_im_s3[SW-1] ? AW'(-num_im_s3) : AW'(num_im_s3);
		end
	end

	// multiply finish and divide range check
	logic [AW:0]   rs_re, rs_im, lm_re, lm_im;
	logic          msat_re, msat_im, dsat_re, dsat_im;
	logic [DW-1:0] mv_re, mv_im;
	logic [CW-1:0] n_re, n_im, dlim;
	always_comb begin
		rs_re   = ({1'b0, mag_re_s4} + ((AW+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
		rs_im   = ({1'b0, mag_im_s4} + ((AW+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
		lm_re   = (AW+1)'(neg_re_s4 ? LIM_N : LIM_P);
		lm_im   = (AW+1)'(neg_im_s4 ? LIM_N : LIM_P);
		msat_re = rs_re > lm_re;
		msat_im = rs_im > lm_im;
		mv_re   = msat_re ? lm_re[DW-1:0] : rs_re[DW-1:0];
		mv_im   = msat_im ? lm_im[DW-1:0] : rs_im[DW-1:0];
		n_re    = CW'(mag_re_s4) << FRAC_BITS;
		n_im    = CW'(mag_im_s4) << FRAC_BITS;
		dlim    = CW'(den_s4) << QB;
		dsat_re = n_re >= dlim;
		dsat_im = n_im >= dlim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s5.valid  <= v_s4;
			ctl_s5.op     <= op_s4;
			ctl_s5.neg_re <= neg_re_s4;
			ctl_s5.neg_im <= neg_im_s4;
			if (op_s4 == cmd_pkg::REQ_MUL) begin
				ctl_s5.sat_re <= msat_re;
				ctl_s5.sat_im <= msat_im;
				ctl_s5.zero   <= 1'b0;
			end else begin
				ctl_s5.sat_re <= dsat_re;
				ctl_s5.sat_im <= dsat_im;
				ctl_s5.zero   <= den_s4 == '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5     <= den_s4;
			rem_re_s5  <= n_re;
			rem_im_s5  <= n_im;
			mres_re_s5 <= neg_re_s4 ? -mv_re : mv_re;
			mres_im_s5 <= neg_im_s4 ? -mv_im : mv_im;
		end
	end

	assign ch_ctl[0]     = ctl_s5;
	assign ch_den[0]     = den_s5;
	assign ch_rem_re[0]  = rem_re_s5;
	assign ch_rem_im[0]  = rem_im_s5;
	assign ch_q_re[0]    = '0;
	assign ch_q_im[0]    = '0;
	assign ch_mres_re[0] = mres_re_s5;
	assign ch_mres_im[0] = mres_im_s5;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		cmd_cell #(
			.DW   (DW),
			.CW   (CW),
			.DENW (DENW),
			.QB   (QB),
			.BIT  (QB-1-k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.in_ctl      (ch_ctl[k]),
			.in_den      (ch_den[k]),
			.in_rem_re   (ch_rem_re[k]),
			.in_rem_im   (ch_rem_im[k]),
			.in_q_re     (ch_q_re[k]),
			.in_q_im     (ch_q_im[k]),
			.in_mres_re  (ch_mres_re[k]),
			.in_mres_im  (ch_mres_im[k]),
			.out_ctl     (ch_ctl[k+1]),
			.out_den     (ch_den[k+1]),
			.out_rem_re  (ch_rem_re[k+1]),
			.out_rem_im  (ch_rem_im[k+1]),
			.out_q_re    (ch_q_re[k+1]),
			.out_q_im    (ch_q_im[k+1]),
			.out_mres_re (ch_mres_re[k+1]),
			.out_mres_im (ch_mres_im[k+1])
		);
	end

	// rounding and output
	cmd_pkg::ctl_t fc;
	logic [QB:0]   qr_re, qr_im, ql_re, ql_im;
	logic          fs_re, fs_im;
	logic [DW-1:0] fv_re, fv_im, o_re, o_im;
	logic          o_sat;
	always_comb begin
		fc    = ch_ctl[QB];
		qr_re = (QB+1)'(ch_q_re[QB]) + (QB+1)'({ch_rem_re[QB], 1'b0} >= (CW+1)'(ch_den[QB]));
		qr_im = (QB+1)'(ch_q_im[QB]) + (QB+1)'({ch_rem_im[QB], 1'b0} >= (CW+1)'(ch_den[QB]));
		ql_re = (QB+1)'(fc.neg_re ? LIM_N : LIM_P);
		ql_im = (QB+1)'(fc.neg_im ? LIM_N : LIM_P);
		fs_re = fc.sat_re || (qr_re > ql_re);
		fs_im = fc.sat_im || (qr_im > ql_im);
		fv_re = fs_re ? ql_re[DW-1:0] : qr_re[DW-1:0];
		fv_im = fs_im ? ql_im[DW-1:0] : qr_im[DW-1:0];
		if (fc.op == cmd_pkg::REQ_MUL) begin
			o_re  = ch_mres_re[QB];
			o_im  = ch_mres_im[QB];
			o_sat = fc.sat_re || fc.sat_im;
		end else if (fc.zero) begin
			o_re  = '0;
			o_im  = '0;
			o_sat = 1'b0;
		end else begin
			o_re  = fc.neg_re ? -fv_re : fv_re;
			o_im  = fc.neg_im ? -fv_im : fv_im;
			o_sat = fs_re || fs_im;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q      <= o_re;
			im_q      <= o_im;
			sat_q     <= o_sat;
			ctl_out_q <= fc;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			(re_q == LIM_P) || (re_q == LIM_N) || (im_q == LIM_P) || (im_q == LIM_N))
		else $error("saturation flag without a clipped part");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ctl_out_q.zero |-> (re_q == '0) && (im_q == '0) && !m_tuser)
		else $error("zero divisor gave a nonzero result");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ch_ctl[QB].valid))
		else $error("result appeared without an item leaving the divider chain");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s5.valid && ctl_s5.zero |-> ctl_s5.op == cmd_pkg::REQ_DIV)
		else $error("zero divisor marked on a multiply item");

endmodule

[sim/complex_multiply_divide_tb.sv]
// testbench for the complex multiply and regularised divide block against a predictor
`timescale 1ns / 1ps

module complex_multiply_divide_tb;

	localparam int FRAC_BITS  = 24;
	localparam int DATA_WIDTH = 32;
	localparam int LATENCY    = DATA_WIDTH + 7;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		cmd_pkg::req_t op;
		logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;
	} bin_t;

	typedef struct {
		logic [DATA_WIDTH-1:0] re, im;
		logic sat;
	} bin_res_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [4*DATA_WIDTH-1:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [2*DATA_WIDTH-1:0] m_tdata;
	logic cfg_valid, cfg_ready;
	logic [cmd_pkg::EPS_W-1:0] cfg_data;

	bin_t pending_bins[$];
	bin_res_t expected_bins[$];
	logic [cmd_pkg::EPS_W-1:0] eps_copy;
	int errors, burst_left, gap_left, idle_cycles, stall_phase;
	logic [15:0] stall_pattern;
	logic full_rate;
	logic s_taken;

	complex_multiply_divide #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [DATA_WIDTH-1:0] scale_part(logic signed [127:0] v, logic is_div,
			logic [127:0] den, inout logic sat);
		logic neg;
		logic [127:0] m, n, q, r, lim;
		neg = v < 0;
		m = neg ? -v : v;
		if (is_div) begin
			if (den == 0)
				return '0;
			n = m << FRAC_BITS;
			q = n / den;
			r = n % den;
			if ((r << 1) >= den)
				q = q + 1;
			m = q;
		end else begin
			m = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		end
		lim = neg ? (128'd1 << (DATA_WIDTH - 1)) : ((128'd1 << (DATA_WIDTH - 1)) - 1);
		if (m > lim) begin
			m = lim;
			sat = 1'b1;
		end
		return neg ? -m[DATA_WIDTH-1:0] : m[DATA_WIDTH-1:0];
	endfunction

	function automatic bin_res_t predict_bin(bin_t b, logic [cmd_pkg::EPS_W-1:0] eps);
		logic signed [127:0] xr, xi, yr, yi;
		logic [127:0] den;
		bin_res_t res;
		xr = b.ar;
		xi = b.ai;
		yr = b.br;
		yi = b.bi;
		res.sat = 1'b0;
		if (b.op == cmd_pkg::REQ_MUL) begin
			res.re = scale_part(xr * yr - xi * yi, 1'b0, 0, res.sat);
			res.im = scale_part(xi * yr + xr * yi, 1'b0, 0, res.sat);
		end else begin
			den = yr * yr + yi * yi + (128'(eps) << FRAC_BITS);
			res.re = scale_part(xr * yr + xi * yi, 1'b1, den, res.sat);
			res.im = scale_part(xi * yr - xr * yi, 1'b1, den, res.sat);
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
			logic [DATA_WIDTH-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// sender: bursts and gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_taken) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = full_rate ? 0 : $urandom_range(0, 6);
			end
			if (gap_left > 0 || pending_bins.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				bin_t b;
				b = pending_bins.pop_front();
				burst_left--;
				s_tvalid <= 1'b1;
				s_tuser <= b.op;
				s_tdata <= {b.bi, b.br, b.ai, b.ar};
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		stall_phase = (stall_phase + 1) % 16;
		if (stall_phase == 0 && $urandom_range(0, 3) == 0)
			stall_pattern = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom);
		m_tready <= full_rate ? 1'b1 : stall_pattern[stall_phase];
	end

	// monitor and watchdog
	always @(posedge clk) begin
		s_taken = s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				bin_t b;
				b.op = cmd_pkg::req_t'(s_tuser);
				{b.bi, b.br, b.ai, b.ar} = s_tdata;
				expected_bins = {expected_bins, predict_bin(b, eps_copy)};
			end
			if (m_tvalid && m_tready) begin
				if (expected_bins.size() == 0) begin
					report_mismatch("unexpected item", m_tdata[DATA_WIDTH-1:0], '0);
				end else begin
					bin_res_t e;
					e = expected_bins.pop_front();
					if (m_tdata[DATA_WIDTH-1:0] !== e.re)
						report_mismatch("out_real", m_tdata[DATA_WIDTH-1:0], e.re);
					if (m_tdata[2*DATA_WIDTH-1:DATA_WIDTH] !== e.im)
						report_mismatch("out_imag", m_tdata[2*DATA_WIDTH-1:DATA_WIDTH], e.im);
					if (m_tuser !== e.sat)
						report_mismatch("saturated", m_tuser, e.sat);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else if (pending_bins.size() != 0 || expected_bins.size() != 0 || s_tvalid
					|| cfg_valid)
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("complex_multiply_divide_tb: errors");
				$finish;
			end
		end
	end

	task automatic write_epsilon(logic [cmd_pkg::EPS_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		eps_copy = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_bin(cmd_pkg::req_t op, logic [DATA_WIDTH-1:0] ar, ai, br, bi);
		bin_t b;
		b.op = op;
		b.ar = ar;
		b.ai = ai;
		b.br = br;
		b.bi = bi;
		pending_bins = {pending_bins, b};
	endtask

	function automatic logic [DATA_WIDTH-1:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
			2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			4: return 32'($signed($urandom_range(0, 8)) - 4);
			default: return 32'($signed($urandom_range(0, 1 << 31)) >>> $urandom_range(0, 28));
		endcase
	endfunction

	task automatic add_random_bins(int n);
		for (int i = 0; i < n; i++)
			add_bin(cmd_pkg::req_t'($urandom_range(0, 1)), rand_operand(), rand_operand(),
				$urandom_range(0, 9) == 0 ? '0 : rand_operand(),
				$urandom_range(0, 9) == 0 ? '0 : rand_operand());
	endtask

	task automatic drain();
		while (pending_bins.size() != 0 || expected_bins.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		logic [cmd_pkg::EPS_W-1:0] eps_steps[4];
		errors = 0;
		burst_left = 0;
		gap_left = 0;
		idle_cycles = 0;
		stall_phase = 0;
		stall_pattern = 16'hffff;
		full_rate = 1'b0;
		s_taken = 1'b0;
		eps_copy = cmd_pkg::EPS_RESET;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of epsilon first
		add_bin(cmd_pkg::REQ_DIV, 32'h01000000, 32'h0, 32'h0, 32'h0);
		add_bin(cmd_pkg::REQ_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		add_bin(cmd_pkg::REQ_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		add_bin(cmd_pkg::REQ_MUL, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		add_bin(cmd_pkg::REQ_MUL, 32'h00800000, 32'h0, 32'h1, 32'h0);
		add_bin(cmd_pkg::REQ_MUL, 32'hff800000, 32'h0, 32'h1, 32'h0);
		add_bin(cmd_pkg::REQ_MUL, 32'h01000000, 32'h02000000, 32'hff000000, 32'h00800000);
		add_bin(cmd_pkg::REQ_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0);
		add_bin(cmd_pkg::REQ_DIV, 32'h01000000, 32'h0, 32'h02000000, 32'h0);
		add_bin(cmd_pkg::REQ_DIV, 32'h0, 32'h01000000, 32'h0, 32'hff000000);
		add_bin(cmd_pkg::REQ_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		add_bin(cmd_pkg::REQ_DIV, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		add_bin(cmd_pkg::REQ_DIV, 32'h00000003, 32'h0, 32'h02000000, 32'h0);
		full_rate = 1'b1;
		drain();
		full_rate = 1'b0;

		// zero divisor needs epsilon zero
		write_epsilon('0);
		add_bin(cmd_pkg::REQ_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
		add_bin(cmd_pkg::REQ_DIV, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
		add_bin(cmd_pkg::REQ_DIV, 32'h1, 32'h1, 32'h1, 32'h0);
		add_bin(cmd_pkg::REQ_MUL, 32'h0, 32'h0, 32'h0, 32'h0);

		eps_steps[0] = '0;
		eps_steps[1] = 16'hffff;
		eps_steps[2] = cmd_pkg::EPS_RESET;
		eps_steps[3] = 16'($urandom);
		for (int p = 0; p < 4; p++) begin
			if (p != 0)
				write_epsilon(eps_steps[p]);
			full_rate = (p == 2);
			add_random_bins(410);
			drain();
		end

		if (errors == 0)
			$display("complex_multiply_divide_tb: clean");
		else
			$display("complex_multiply_divide_tb: errors");
		$finish;
	end

endmodule
